// ===== rtl/core/psd_pkg.sv =====
`timescale 1ns / 1ps

package psd_pkg;

  // coordinate width and the widths that follow from it
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int MAG_W      = 2 * COORD_BITS + 1;
  localparam int SQ_W       = 2 * MAG_W;

  // fixed field widths
  localparam int LEN_W  = 33;
  localparam int DIST_W = 35;

  // dividend as seen by the divider row: top part compared with the divisor
  localparam int NUM_W = (SQ_W > DIST_W + LEN_W) ? SQ_W : DIST_W + LEN_W;
  localparam int TOP_W = NUM_W - DIST_W;

  // endpoint distance saturation
  localparam int EXT_W = (PROD_W > DIST_W) ? PROD_W : DIST_W;

  // stream widths, fields packed from bit 0 and padded to whole bytes
  localparam int S_TDATA_BITS = 6 * COORD_BITS + LEN_W;
  localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W    = ((DIST_W + 7) / 8) * 8;
  localparam int M_TUSER_W    = 3;

  typedef enum logic [1:0] {
    PART_INTERIOR = 2'd0,
    PART_START    = 2'd1,
    PART_END      = 2'd2
  } psd_part_e;

  // payload handed from cell to cell along the divider row
  typedef struct packed {
    logic [LEN_W-1:0]  rem;   // partial remainder, always below dvs
    logic [LEN_W-1:0]  dvs;   // divisor
    logic [DIST_W-1:0] lq;    // dividend bits still to use, quotient bits shifted in
    psd_part_e         part;
    logic              zd;
  } psd_cell_t;

endpackage

// ===== rtl/core/psd_front.sv =====
`timescale 1ns / 1ps

module psd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [psd_pkg::S_TDATA_W-1:0]  tdata_i,
  output logic                           valid_o,
  output psd_pkg::psd_cell_t             cell_o
);
  import psd_pkg::*;

  localparam int OFS_SX  = 0;
  localparam int OFS_SY  = COORD_BITS;
  localparam int OFS_EX  = 2 * COORD_BITS;
  localparam int OFS_EY  = 3 * COORD_BITS;
  localparam int OFS_PX  = 4 * COORD_BITS;
  localparam int OFS_PY  = 5 * COORD_BITS;
  localparam int OFS_LEN = 6 * COORD_BITS;

  logic signed [COORD_BITS-1:0] sx, sy, ex, ey, px, py;

  // stage 1: coordinate differences
  logic                     v1_q;
  logic signed [DIFF_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [LEN_W-1:0]         len1_q;

  // stage 2: products
  logic                     v2_q;
  logic signed [PROD_W-1:0] pab0_q, pab1_q, pac0_q, pac1_q;
  logic signed [PROD_W-1:0] pb0_q, pb1_q, pc0_q, pc1_q, px0_q, px1_q;
  logic [LEN_W-1:0]         len2_q;

  // stage 3: sums
  logic                    v3_q;
  logic signed [SUM_W-1:0] ab_q, ac_q, cr_q;
  logic [PROD_W-1:0]       db_q, dc_q;
  logic [LEN_W-1:0]        len3_q;

  // stage 4: branch decision and cross magnitude
  logic              v4_q;
  psd_part_e         part4_d, part4_q;
  logic              zd4_d, zd4_q;
  logic [PROD_W-1:0] ep_sel;
  logic [EXT_W-1:0]  ep_ext;
  logic [DIST_W-1:0] ep4_d, ep4_q;
  logic [MAG_W-1:0]  crm4_q;
  logic [LEN_W-1:0]  len4_q;

  // stage 5: cross squared
  logic              v5_q;
  psd_part_e         part5_q;
  logic              zd5_q;
  logic [DIST_W-1:0] ep5_q;
  logic [SQ_W-1:0]   sq5_q;
  logic [LEN_W-1:0]  len5_q;

  // stage 6: divider set-up
  logic             v6_q;
  logic [NUM_W-1:0] num;
  logic [TOP_W-1:0] top;
  psd_cell_t        cell6_d, cell6_q;

  assign sx = tdata_i[OFS_SX +: COORD_BITS];
  assign sy = tdata_i[OFS_SY +: COORD_BITS];
  assign ex = tdata_i[OFS_EX +: COORD_BITS];
  assign ey = tdata_i[OFS_EY +: COORD_BITS];
  assign px = tdata_i[OFS_PX +: COORD_BITS];
  assign py = tdata_i[OFS_PY +: COORD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= DIFF_W'(ex) - DIFF_W'(sx);
      ay_q   <= DIFF_W'(ey) - DIFF_W'(sy);
      bx_q   <= DIFF_W'(px) - DIFF_W'(sx);
      by_q   <= DIFF_W'(py) - DIFF_W'(sy);
      cx_q   <= DIFF_W'(px) - DIFF_W'(ex);
      cy_q   <= DIFF_W'(py) - DIFF_W'(ey);
      len1_q <= tdata_i[OFS_LEN +: LEN_W];

      pab0_q <= PROD_W'(ax_q) * PROD_W'(bx_q);
      pab1_q <= PROD_W'(ay_q) * PROD_W'(by_q);
      pac0_q <= PROD_W'(ax_q) * PROD_W'(cx_q);
      pac1_q <= PROD_W'(ay_q) * PROD_W'(cy_q);
      pb0_q  <= PROD_W'(bx_q) * PROD_W'(bx_q);
      pb1_q  <= PROD_W'(by_q) * PROD_W'(by_q);
      pc0_q  <= PROD_W'(cx_q) * PROD_W'(cx_q);
      pc1_q  <= PROD_W'(cy_q) * PROD_W'(cy_q);
      px0_q  <= PROD_W'(ax_q) * PROD_W'(by_q);
      px1_q  <= PROD_W'(ay_q) * PROD_W'(bx_q);
      len2_q <= len1_q;

      ab_q   <= SUM_W'(pab0_q) + SUM_W'(pab1_q);
      ac_q   <= SUM_W'(pac0_q) + SUM_W'(pac1_q);
      cr_q   <= SUM_W'(px0_q) - SUM_W'(px1_q);
      // squares are never negative and their sum fits
      db_q   <= $unsigned(pb0_q) + $unsigned(pb1_q);
      dc_q   <= $unsigned(pc0_q) + $unsigned(pc1_q);
      len3_q <= len2_q;

      part4_q <= part4_d;
      zd4_q   <= zd4_d;
      ep4_q   <= ep4_d;
      crm4_q  <= MAG_W'(cr_q[SUM_W-1] ? (~cr_q + 1'b1) : cr_q);
      len4_q  <= len3_q;

      part5_q <= part4_q;
      zd5_q   <= zd4_q;
      ep5_q   <= ep4_q;
      sq5_q   <= SQ_W'(crm4_q) * SQ_W'(crm4_q);
      len5_q  <= len4_q;

      cell6_q <= cell6_d;
    end
  end

  always_comb begin
    zd4_d  = 1'b0;
    ep_sel = db_q;
    if (ab_q[SUM_W-1] || (ab_q == '0)) begin
      part4_d = PART_START;
    end else if (!ac_q[SUM_W-1]) begin
      part4_d = PART_END;
      ep_sel  = dc_q;
    end else begin
      part4_d = PART_INTERIOR;
      zd4_d   = (len3_q == '0);
    end
    ep_ext = EXT_W'(ep_sel);
    if (ep_ext > EXT_W'({DIST_W{1'b1}})) begin
      ep4_d = '1;
    end else begin
      ep4_d = DIST_W'(ep_ext);
    end
  end

  // endpoints and saturated results run through the row as a division by one
  always_comb begin
    num          = NUM_W'(sq5_q);
    top          = num[NUM_W-1:DIST_W];
    cell6_d.part = part5_q;
    cell6_d.zd   = zd5_q;
    cell6_d.rem  = '0;
    cell6_d.dvs  = LEN_W'(1);
    cell6_d.lq   = ep5_q;
    if (part5_q == PART_INTERIOR) begin
      if (zd5_q || (top >= TOP_W'(len5_q))) begin
        cell6_d.lq = '1;
      end else begin
        cell6_d.rem = top[LEN_W-1:0];
        cell6_d.dvs = len5_q;
        cell6_d.lq  = num[DIST_W-1:0];
      end
    end
  end

  assign valid_o = v6_q;
  assign cell_o  = cell6_q;

endmodule

// ===== rtl/core/psd_div_cell.sv =====
`timescale 1ns / 1ps

module psd_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  psd_pkg::psd_cell_t  cell_i,
  output logic                valid_o,
  output psd_pkg::psd_cell_t  cell_o
);
  import psd_pkg::*;

  logic [LEN_W:0]   trial;
  logic             ge;
  logic [LEN_W:0]   diff;
  psd_cell_t        cell_d, cell_q;
  logic             valid_q;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial  = {cell_i.rem, cell_i.lq[DIST_W-1]};
    ge     = (trial >= {1'b0, cell_i.dvs});
    diff   = trial - {1'b0, cell_i.dvs};
    cell_d = cell_i;
    cell_d.rem = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    cell_d.lq  = {cell_i.lq[DIST_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== rtl/core/point_segment_distance_sq.sv =====
`timescale 1ns / 1ps

// squared distance from a test point to a line segment
// input channel s_axis: one beat carries a segment start, end, test point and
//   the squared segment length; output channel m_axis: one beat per input beat,
//   in the same order, carrying the squared distance and which part is nearest
// pipeline: six front stages (differences, products, sums, branch choice, cross
//   squared, divider set-up), one divider cell per quotient bit (35 cells) and the
//   output register lie between an accepted input beat and m_axis_tvalid_o
// throughput: one beat per cycle unless frozen by a stall, set by the row of
//   divider cells, each resolving one quotient bit and handing on the remainder
// stall: the output register is backed by a one-beat skid register; a stalled
//   receiver fills the skid, after which the whole pipeline freezes and
//   s_axis_tready_o drops until the skid drains
// reset: rst_ni clears every valid flag at once; nothing else needs clearing
//   and s_axis_tready_o is already high when reset is released
// interior case: floor(cross^2 / length_sq), saturated at the 35-bit maximum;
//   a zero length_sq there gives the maximum and raises zero_divisor
module point_segment_distance_sq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // start_x, start_y, end_x, end_y, point_x, point_y, length_sq, zero pad
  input  logic [psd_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // m_axis
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // distance_sq, zero pad
  output logic [psd_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // nearest_part, zero_divisor
  output logic [psd_pkg::M_TUSER_W-1:0]  m_axis_tuser_o
);
  import psd_pkg::*;

  // pipeline advance: held only while the skid register is occupied
  logic      en;

  // divider row, entry 0 fed by the front stages
  logic      row_v [DIST_W+1];
  psd_cell_t row_d [DIST_W+1];

  logic      leave;
  psd_cell_t out_d, out_q, skid_d, skid_q;
  logic      out_v_d, out_v_q, skid_v_d, skid_v_q;

  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .tdata_i (s_axis_tdata_i),
    .valid_o (row_v[0]),
    .cell_o  (row_d[0])
  );

  for (genvar g = 0; g < DIST_W; g++) begin : g_cell
    psd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (row_v[g]),
      .cell_i  (row_d[g]),
      .valid_o (row_v[g+1]),
      .cell_o  (row_d[g+1])
    );
  end

  // a finished beat leaves the row whenever the row advances
  assign leave = row_v[DIST_W] && en;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || m_axis_tready_i) begin
      // output register free or being emptied this cycle
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = row_d[DIST_W];
        out_v_d = leave;
      end
    end else if (leave) begin
      // receiver stalled: park the arriving beat
      skid_d   = row_d[DIST_W];
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = M_TDATA_W'(out_q.lq);
  assign m_axis_tuser_o  = {out_q.zd, out_q.part};

endmodule
